/* src/bfm_pkg.sv */
// Shared constants, codes and types for the Brainfuck machine step core.
// Used by bfm_code_store, bfm_data_store and brainfuck_machine_step_core.
package bfm_pkg;

    // Store sizes
    localparam int DATA_CELLS = 32768;
    localparam int CODE_DEPTH = 4096;
    localparam int LOOP_DEPTH = 256;

    // Derived widths
    localparam int DATA_AW = $clog2(DATA_CELLS);
    localparam int CODE_AW = (CODE_DEPTH > 1) ? $clog2(CODE_DEPTH) : 1;
    localparam int PC_W    = $clog2(CODE_DEPTH + 1);
    localparam int LOOP_AW = (LOOP_DEPTH > 1) ? $clog2(LOOP_DEPTH) : 1;
    localparam int LOOP_DW = $clog2(LOOP_DEPTH + 1);

    // Instruction codes
    localparam logic [2:0] SYM_RIGHT = 3'd0;
    localparam logic [2:0] SYM_LEFT  = 3'd1;
    localparam logic [2:0] SYM_INC   = 3'd2;
    localparam logic [2:0] SYM_DEC   = 3'd3;
    localparam logic [2:0] SYM_OUT   = 3'd4;
    localparam logic [2:0] SYM_IN    = 3'd5;
    localparam logic [2:0] SYM_OPEN  = 3'd6;
    localparam logic [2:0] SYM_CLOSE = 3'd7;

    // Fault codes
    localparam logic [1:0] FAULT_OK        = 2'd0;
    localparam logic [1:0] FAULT_STACK     = 2'd1;
    localparam logic [1:0] FAULT_UNMATCHED = 2'd2;
    localparam logic [1:0] FAULT_CODE_FULL = 2'd3;

    typedef struct packed {
        logic               load;
        logic [2:0]         symbol;
        logic [CODE_AW-1:0] raddr;
    } code_req_t;

    typedef struct packed {
        logic               we;
        logic [DATA_AW-1:0] addr;
        logic [7:0]         wdata;
    } data_req_t;

    typedef struct packed {
        logic       out_valid;
        logic [7:0] out_byte;
        logic       took_input;
        logic       halted;
        logic [1:0] fault;
    } result_t;

endpackage

/* src/bfm_code_store.sv */
// Code store: instruction memory with append port, length count and one
// registered read port. Depends on bfm_pkg.
module bfm_code_store (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  bfm_pkg::code_req_t       req,
    output logic [2:0]               rdata,
    output logic [bfm_pkg::PC_W-1:0] code_len
);

    logic [2:0]               mem [bfm_pkg::CODE_DEPTH];
    logic [2:0]               rdata_reg;
    logic [bfm_pkg::PC_W-1:0] len_reg;
    logic [bfm_pkg::PC_W-1:0] len_next;

    // caller only raises load when not full
    assign len_next = len_reg + bfm_pkg::PC_W'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg <= '0;
        end else if (req.load) begin
            len_reg <= len_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.load) begin
            mem[len_reg[bfm_pkg::CODE_AW-1:0]] <= req.symbol;
        end
        rdata_reg <= mem[req.raddr];
    end

    assign rdata    = rdata_reg;
    assign code_len = len_reg;

endmodule

/* src/bfm_data_store.sv */
// Data cell memory with a clearing sweep after reset and one registered
// read port sharing the write address. Depends on bfm_pkg.
module bfm_data_store (
    input  logic               aclk,
    input  logic               aresetn,
    input  bfm_pkg::data_req_t req,
    output logic [7:0]         rdata,
    output logic               ready
);

    logic [7:0]                  mem [bfm_pkg::DATA_CELLS];
    logic [7:0]                  rdata_reg;
    logic                        clr_busy_reg;
    logic [bfm_pkg::DATA_AW-1:0] clr_addr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else if (clr_busy_reg) begin
            if (clr_addr_reg == bfm_pkg::DATA_AW'(bfm_pkg::DATA_CELLS - 1)) begin
                clr_busy_reg <= 1'b0;
            end
            clr_addr_reg <= clr_addr_reg + bfm_pkg::DATA_AW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (clr_busy_reg) begin
            mem[clr_addr_reg] <= 8'd0;
        end else if (req.we) begin
            mem[req.addr] <= req.wdata;
        end
        rdata_reg <= mem[req.addr];
    end

    assign rdata = rdata_reg;
    assign ready = !clr_busy_reg;

endmodule

/* src/brainfuck_machine_step_core.sv */
// Brainfuck machine step core: top level with sequencer and loop stack.
// Depends on bfm_pkg, bfm_code_store and bfm_data_store.
//
// Each input item either appends one instruction to the code store
// (command 0) or executes one instruction (command 1), and yields exactly one
// result item. Loads, code-store-full loads and steps past the end of the
// code finish in the cycle they are accepted. Any other step passes through EXEC:
// the accept cycle launches the synchronous reads of the code store, the
// current data cell and the loop stack top, and the next cycle executes and
// writes back. A '[' on a zero cell scans forward through the code store one
// instruction per cycle over its single read port, until it passes the matching
// ']' or runs off the end of the code. After reset the data memory is cleared
// one cell per cycle, all DATA_CELLS cells (32768 by default), with s_ready low.
// Results sit in an output register, so the next item is accepted while the
// previous result still waits on m_ready; a finished result holds the
// sequencer only if that register is still occupied.
module brainfuck_machine_step_core (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_command,
    input  logic [2:0] s_code_symbol,
    input  logic [7:0] s_input_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_out_valid,
    output logic [7:0] m_out_byte,
    output logic       m_took_input,
    output logic       m_halted,
    output logic [1:0] m_fault
);

    localparam int PC_W    = bfm_pkg::PC_W;
    localparam int CODE_AW = bfm_pkg::CODE_AW;
    localparam int DATA_AW = bfm_pkg::DATA_AW;
    localparam int LOOP_AW = bfm_pkg::LOOP_AW;
    localparam int LOOP_DW = bfm_pkg::LOOP_DW;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;
    localparam logic [1:0] ST_RESP = 2'd3;

    // sequencer state
    logic [1:0]         state_reg,     state_next;
    logic [PC_W-1:0]    pc_reg,        pc_next;
    logic [DATA_AW-1:0] cp_reg,        cp_next;
    logic [LOOP_DW-1:0] depth_reg,     depth_next;
    logic [7:0]         in_byte_reg,   in_byte_next;
    // forward bracket scan
    logic [PC_W-1:0]    scan_addr_reg, scan_addr_next;
    logic [PC_W-1:0]    chk_addr_reg,  chk_addr_next;
    logic               chk_valid_reg, chk_valid_next;
    logic [PC_W-1:0]    nest_reg,      nest_next;
    // results
    bfm_pkg::result_t   m_res_reg,     m_res_next;
    logic               m_valid_reg,   m_valid_next;
    bfm_pkg::result_t   res_reg,       res_next;

    // loop stack memory
    logic [CODE_AW-1:0] stack_mem [bfm_pkg::LOOP_DEPTH];
    logic [CODE_AW-1:0] top_reg;
    logic [LOOP_DW-1:0] depth_dec;
    logic               push;

    // store ports
    bfm_pkg::code_req_t code_req;
    bfm_pkg::data_req_t data_req;
    logic [2:0]         code_rdata;
    logic [PC_W-1:0]    code_len;
    logic [7:0]         cell_rdata;
    logic               data_ready;

    logic               accept;
    logic               out_free;
    logic               finish;
    bfm_pkg::result_t   fin_res;
    logic               code_full;
    logic               scan_more;

    bfm_code_store u_code (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (code_req),
        .rdata    (code_rdata),
        .code_len (code_len)
    );

    bfm_data_store u_data (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (data_req),
        .rdata   (cell_rdata),
        .ready   (data_ready)
    );

    assign s_ready   = (state_reg == ST_IDLE) && data_ready;
    assign accept    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign code_full = (code_len == PC_W'(bfm_pkg::CODE_DEPTH));
    assign depth_dec = depth_reg - LOOP_DW'(1);
    assign scan_more = (scan_addr_reg < code_len);

    // stack top is read at every edge; depth only moves in EXEC
    always_ff @(posedge aclk) begin
        if (push) begin
            stack_mem[depth_reg[LOOP_AW-1:0]] <= pc_reg[CODE_AW-1:0];
        end
        top_reg <= stack_mem[depth_dec[LOOP_AW-1:0]];
    end

    always_comb begin
        state_next     = state_reg;
        pc_next        = pc_reg;
        cp_next        = cp_reg;
        depth_next     = depth_reg;
        in_byte_next   = in_byte_reg;
        scan_addr_next = scan_addr_reg;
        chk_addr_next  = chk_addr_reg;
        chk_valid_next = chk_valid_reg;
        nest_next      = nest_reg;
        res_next       = res_reg;
        push           = 1'b0;
        finish         = 1'b0;
        fin_res        = '0;

        code_req.load   = 1'b0;
        code_req.symbol = s_code_symbol;
        code_req.raddr  = (state_reg == ST_SCAN) ? scan_addr_reg[CODE_AW-1:0]
                                                 : pc_reg[CODE_AW-1:0];
        data_req.we     = 1'b0;
        data_req.addr   = cp_reg;
        data_req.wdata  = cell_rdata;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (!s_command) begin
                        // load: append unless the store is full
                        finish = 1'b1;
                        if (code_full) begin
                            fin_res.fault = bfm_pkg::FAULT_CODE_FULL;
                        end else begin
                            code_req.load = 1'b1;
                        end
                    end else if (pc_reg >= code_len) begin
                        finish         = 1'b1;
                        fin_res.halted = 1'b1;
                    end else begin
                        // reads of code, cell and stack top launch at this edge
                        in_byte_next = s_input_byte;
                        state_next   = ST_EXEC;
                    end
                end
            end

            ST_EXEC: begin
                finish  = 1'b1;
                pc_next = pc_reg + PC_W'(1);
                unique case (code_rdata)
                    bfm_pkg::SYM_RIGHT: begin
                        cp_next = (cp_reg == DATA_AW'(bfm_pkg::DATA_CELLS - 1))
                                  ? '0 : cp_reg + DATA_AW'(1);
                    end
                    bfm_pkg::SYM_LEFT: begin
                        cp_next = (cp_reg == '0) ? DATA_AW'(bfm_pkg::DATA_CELLS - 1)
                                                 : cp_reg - DATA_AW'(1);
                    end
                    bfm_pkg::SYM_INC: begin
                        data_req.we    = 1'b1;
                        data_req.wdata = cell_rdata + 8'd1;
                    end
                    bfm_pkg::SYM_DEC: begin
                        data_req.we    = 1'b1;
                        data_req.wdata = cell_rdata - 8'd1;
                    end
                    bfm_pkg::SYM_OUT: begin
                        fin_res.out_valid = 1'b1;
                        fin_res.out_byte  = cell_rdata;
                    end
                    bfm_pkg::SYM_IN: begin
                        data_req.we        = 1'b1;
                        data_req.wdata     = in_byte_reg;
                        fin_res.took_input = 1'b1;
                    end
                    bfm_pkg::SYM_OPEN: begin
                        if (cell_rdata == 8'd0) begin
                            // skip to just past the matching ']'
                            finish         = 1'b0;
                            pc_next        = pc_reg;
                            scan_addr_next = pc_reg + PC_W'(1);
                            chk_valid_next = 1'b0;
                            nest_next      = PC_W'(1);
                            state_next     = ST_SCAN;
                        end else if (depth_reg == LOOP_DW'(bfm_pkg::LOOP_DEPTH)) begin
                            fin_res.fault = bfm_pkg::FAULT_STACK;
                            pc_next       = pc_reg;
                        end else begin
                            push       = 1'b1;
                            depth_next = depth_reg + LOOP_DW'(1);
                        end
                    end
                    bfm_pkg::SYM_CLOSE: begin
                        if (depth_reg == '0) begin
                            fin_res.fault = bfm_pkg::FAULT_UNMATCHED;
                            pc_next       = pc_reg;
                        end else if (cell_rdata != 8'd0) begin
                            pc_next = PC_W'(top_reg) + PC_W'(1);
                        end else begin
                            depth_next = depth_dec;
                        end
                    end
                endcase
            end

            ST_SCAN: begin
                // chk_* describes the symbol now on code_rdata
                if (chk_valid_reg && (code_rdata == bfm_pkg::SYM_CLOSE)
                        && (nest_reg == PC_W'(1))) begin
                    finish  = 1'b1;
                    pc_next = chk_addr_reg + PC_W'(1);
                end else if (!chk_valid_reg && !scan_more) begin
                    // no match before the end of the code
                    finish  = 1'b1;
                    pc_next = code_len;
                end else begin
                    if (chk_valid_reg && (code_rdata == bfm_pkg::SYM_OPEN)) begin
                        nest_next = nest_reg + PC_W'(1);
                    end else if (chk_valid_reg && (code_rdata == bfm_pkg::SYM_CLOSE)) begin
                        nest_next = nest_reg - PC_W'(1);
                    end
                    chk_valid_next = scan_more;
                    chk_addr_next  = scan_addr_reg;
                    if (scan_more) begin
                        scan_addr_next = scan_addr_reg + PC_W'(1);
                    end
                end
            end

            ST_RESP: begin
                // result parked until the output register frees up
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
        endcase

        if (finish) begin
            if (out_free) begin
                state_next = ST_IDLE;
            end else begin
                res_next   = fin_res;
                state_next = ST_RESP;
            end
        end
    end

    // output register
    always_comb begin
        m_res_next   = m_res_reg;
        m_valid_next = m_valid_reg && !m_ready;
        if (finish && out_free) begin
            m_res_next   = fin_res;
            m_valid_next = 1'b1;
        end else if ((state_reg == ST_RESP) && out_free) begin
            m_res_next   = res_reg;
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            pc_reg        <= '0;
            cp_reg        <= '0;
            depth_reg     <= '0;
            chk_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            cp_reg        <= cp_next;
            depth_reg     <= depth_next;
            chk_valid_reg <= chk_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_byte_reg   <= in_byte_next;
        scan_addr_reg <= scan_addr_next;
        chk_addr_reg  <= chk_addr_next;
        nest_reg      <= nest_next;
        res_reg       <= res_next;
        m_res_reg     <= m_res_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_out_valid  = m_res_reg.out_valid;
    assign m_out_byte   = m_res_reg.out_byte;
    assign m_took_input = m_res_reg.took_input;
    assign m_halted     = m_res_reg.halted;
    assign m_fault      = m_res_reg.fault;

endmodule

/* tb/sv/tb.sv */
// Self-checking bench for brainfuck_machine_step_core: random programs, exact prediction.
// Depends on bfm_pkg and the core RTL; needs no files or arguments at run time.
module tb;

    localparam int CYCLE_LIMIT  = 600000;  // covers the clear pass after reset and stalls
    localparam int TAIL_CYCLES  = 64;      // quiet time after the last result
    localparam int RANDOM_ITEMS = 550;
    localparam int RUN_CAP      = 3000;    // safety bound on steps per program chunk

    // One queued input item together with the result the predictor gave for it.
    typedef struct packed {
        logic             cmd;
        logic [2:0]       sym;
        logic [7:0]       byt;
        bfm_pkg::result_t want;
    } bf_item_t;

    logic       aclk          = 1'b0;
    logic       aresetn       = 1'b0;
    logic       s_valid       = 1'b0;
    logic       s_command     = 1'b0;
    logic [2:0] s_code_symbol = '0;
    logic [7:0] s_input_byte  = '0;
    logic       m_ready       = 1'b0;
    logic       s_ready;
    logic       m_valid;
    logic       m_out_valid;
    logic [7:0] m_out_byte;
    logic       m_took_input;
    logic       m_halted;
    logic [1:0] m_fault;

    bf_item_t         pending_items[$];     // issued, not yet accepted
    bfm_pkg::result_t expected_results[$];  // accepted, result not yet seen
    logic [2:0]       snippet[$];           // program chunk under construction

    int tx_idle = 34;                 // percent of cycles the sender holds back
    int rx_idle = 52;                 // percent of cycles m_ready is low
    int errors  = 0;
    int issued  = 0;
    int results_seen = 0;
    int cycles  = 0;

    // Predictor state: a private copy of the machine.
    bit [2:0]                  prog_mem  [bfm_pkg::CODE_DEPTH];
    bit [7:0]                  tape      [bfm_pkg::DATA_CELLS];
    bit [bfm_pkg::CODE_AW-1:0] ret_stack [bfm_pkg::LOOP_DEPTH];
    bit [bfm_pkg::PC_W-1:0]    prog_len   = '0;
    bit [bfm_pkg::PC_W-1:0]    pc         = '0;
    bit [bfm_pkg::DATA_AW-1:0] ptr        = '0;
    bit [bfm_pkg::LOOP_DW-1:0] nest_depth = '0;

    brainfuck_machine_step_core dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_command     (s_command),
        .s_code_symbol (s_code_symbol),
        .s_input_byte  (s_input_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_valid   (m_out_valid),
        .m_out_byte    (m_out_byte),
        .m_took_input  (m_took_input),
        .m_halted      (m_halted),
        .m_fault       (m_fault)
    );

    always #4 aclk = ~aclk;

    // Run-away guard. Counts every cycle, including the clear pass after reset.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic flag_error(input string msg);
        errors++;
        $display("ERROR t=%0t result %0d: %s", $time, results_seen, msg);
    endtask

    // Executes one item on the private machine and returns its result.
    function automatic bfm_pkg::result_t bf_predict(input logic cmd, input logic [2:0] sym,
                                                    input logic [7:0] byt);
        bfm_pkg::result_t       r;
        logic [7:0]             cur_val;
        bit [bfm_pkg::PC_W-1:0] nxt;
        bit [bfm_pkg::PC_W-1:0] scan;
        int                     nest;
        bit                     found;
        r = '0;
        if (!cmd) begin
            // load: append unless the store is full
            if (prog_len >= bfm_pkg::CODE_DEPTH) begin
                r.fault = bfm_pkg::FAULT_CODE_FULL;
            end else begin
                prog_mem[prog_len] = sym;
                prog_len = prog_len + 1'b1;
            end
        end else if (pc >= prog_len) begin
            r.halted = 1'b1;
        end else begin
            cur_val = tape[ptr];
            nxt     = pc + 1'b1;
            case (prog_mem[pc])
                bfm_pkg::SYM_RIGHT:
                    ptr = (ptr == bfm_pkg::DATA_CELLS - 1) ? '0 : ptr + 1'b1;
                bfm_pkg::SYM_LEFT:
                    ptr = (ptr == 0) ? bfm_pkg::DATA_AW'(bfm_pkg::DATA_CELLS - 1)
                                     : ptr - 1'b1;
                bfm_pkg::SYM_INC:   tape[ptr] = cur_val + 8'd1;
                bfm_pkg::SYM_DEC:   tape[ptr] = cur_val - 8'd1;
                bfm_pkg::SYM_OUT: begin
                    r.out_valid = 1'b1;
                    r.out_byte  = cur_val;
                end
                bfm_pkg::SYM_IN: begin
                    tape[ptr]    = byt;
                    r.took_input = 1'b1;
                end
                bfm_pkg::SYM_OPEN: begin
                    if (cur_val == 8'd0) begin
                        // forward scan to just past the matching close, else to the end
                        nxt   = prog_len;
                        nest  = 1;
                        found = 1'b0;
                        scan  = pc + 1'b1;
                        while (!found && scan < prog_len) begin
                            if (prog_mem[scan] == bfm_pkg::SYM_OPEN) begin
                                nest++;
                            end else if (prog_mem[scan] == bfm_pkg::SYM_CLOSE) begin
                                nest--;
                                if (nest == 0) begin
                                    nxt   = scan + 1'b1;
                                    found = 1'b1;
                                end
                            end
                            scan = scan + 1'b1;
                        end
                    end else if (nest_depth >= bfm_pkg::LOOP_DEPTH) begin
                        r.fault = bfm_pkg::FAULT_STACK;
                        nxt     = pc;
                    end else begin
                        ret_stack[nest_depth] = pc[bfm_pkg::CODE_AW-1:0];
                        nest_depth = nest_depth + 1'b1;
                    end
                end
                bfm_pkg::SYM_CLOSE: begin
                    if (nest_depth == 0) begin
                        r.fault = bfm_pkg::FAULT_UNMATCHED;
                        nxt     = pc;
                    end else if (cur_val != 8'd0) begin
                        nxt = ret_stack[nest_depth - 1'b1] + 1'b1;
                    end else begin
                        nest_depth = nest_depth - 1'b1;
                    end
                end
                default: ;
            endcase
            pc = nxt;
        end
        return r;
    endfunction

    // Bytes lean toward the extremes now and then.
    function automatic logic [7:0] rand_byte();
        case ($urandom_range(7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [2:0] rand_op(input bit moves);
        case ($urandom_range(moves ? 0 : 2, 5))
            0:       return bfm_pkg::SYM_RIGHT;
            1:       return bfm_pkg::SYM_LEFT;
            2:       return bfm_pkg::SYM_INC;
            3:       return bfm_pkg::SYM_DEC;
            4:       return bfm_pkg::SYM_OUT;
            default: return bfm_pkg::SYM_IN;
        endcase
    endfunction

    task automatic issue(input logic cmd, input logic [2:0] sym, input logic [7:0] byt);
        bf_item_t it;
        it.cmd  = cmd;
        it.sym  = sym;
        it.byt  = byt;
        it.want = bf_predict(cmd, sym, byt);
        pending_items.push_back(it);
        issued++;
    endtask

    task automatic load_sym(input logic [2:0] sym);
        issue(1'b0, sym, rand_byte());
    endtask

    // A ',' that feeds a loop counter gets a small value so the loop ends soon.
    task automatic step_auto();
        logic [7:0] byt;
        byt = rand_byte();
        if (pc + 1 < prog_len && prog_mem[pc] == bfm_pkg::SYM_IN
                && prog_mem[pc + 1] == bfm_pkg::SYM_OPEN)
            byt = 8'($urandom_range(3));
        issue(1'b1, 3'($urandom), byt);
    endtask

    task automatic run_program();
        int n;
        n = 0;
        while (pc < prog_len && n < RUN_CAP) begin
            step_auto();
            n++;
        end
    endtask

    // Counted loop ",[> body <-]": its counter is set by ',' and only the final
    // '-' touches it, so it always terminates. May hold one inner loop of the
    // same shape one cell further right.
    function automatic void add_loop();
        snippet.push_back(bfm_pkg::SYM_IN);
        snippet.push_back(bfm_pkg::SYM_OPEN);
        snippet.push_back(bfm_pkg::SYM_RIGHT);
        repeat ($urandom_range(3)) snippet.push_back(rand_op(1'b0));
        if ($urandom_range(1)) begin
            snippet.push_back(bfm_pkg::SYM_IN);
            snippet.push_back(bfm_pkg::SYM_OPEN);
            snippet.push_back(bfm_pkg::SYM_RIGHT);
            repeat ($urandom_range(1, 2)) snippet.push_back(rand_op(1'b0));
            snippet.push_back(bfm_pkg::SYM_LEFT);
            snippet.push_back(bfm_pkg::SYM_DEC);
            snippet.push_back(bfm_pkg::SYM_CLOSE);
        end
        snippet.push_back(bfm_pkg::SYM_LEFT);
        snippet.push_back(bfm_pkg::SYM_DEC);
        snippet.push_back(bfm_pkg::SYM_CLOSE);
    endfunction

    // Appends one well-formed chunk and runs it to the end. Straight-line chunks
    // interleave loads and steps; chunks with loops are loaded whole first, since
    // stepping into a half-loaded loop could leave the machine stuck.
    task automatic add_chunk();
        bit looped;
        looped = 1'b0;
        snippet.delete();
        repeat ($urandom_range(1, 6)) begin
            if ($urandom_range(3) == 0) begin
                add_loop();
                looped = 1'b1;
            end else begin
                snippet.push_back(rand_op(1'b1));
            end
        end
        if ($urandom_range(5) == 0)
            step_auto();                // program counter at the end: halted
        foreach (snippet[i]) begin
            load_sym(snippet[i]);
            if (!looped && $urandom_range(1))
                step_auto();
        end
        run_program();
        // lone '[' on a zero cell: scan finds no match and lands at the end
        if (tape[ptr] == 8'd0 && $urandom_range(7) == 0) begin
            load_sym(bfm_pkg::SYM_OPEN);
            step_auto();
            step_auto();
        end
    endtask

    task automatic wait_all_done();
        while (pending_items.size() != 0 || expected_results.size() != 0)
            @(posedge aclk);
    endtask

    // Sender: presents the queue head, holds it until taken, idles at random.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_results.push_back(pending_items[0].want);
                void'(pending_items.pop_front());
            end
            if (!s_valid || s_ready) begin
                if (pending_items.size() != 0 && $urandom_range(99) >= tx_idle) begin
                    s_valid       <= 1'b1;
                    s_command     <= pending_items[0].cmd;
                    s_code_symbol <= pending_items[0].sym;
                    s_input_byte  <= pending_items[0].byt;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random back-pressure, every taken result checked in order.
    always @(posedge aclk) begin : result_monitor
        bfm_pkg::result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    flag_error("result with no item outstanding");
                end else begin
                    want = expected_results.pop_front();
                    if (m_out_valid !== want.out_valid)
                        flag_error($sformatf("out_valid %b, want %b", m_out_valid,
                                             want.out_valid));
                    if (m_out_byte !== want.out_byte)
                        flag_error($sformatf("out_byte %h, want %h", m_out_byte,
                                             want.out_byte));
                    if (m_took_input !== want.took_input)
                        flag_error($sformatf("took_input %b, want %b", m_took_input,
                                             want.took_input));
                    if (m_halted !== want.halted)
                        flag_error($sformatf("halted %b, want %b", m_halted, want.halted));
                    if (m_fault !== want.fault)
                        flag_error($sformatf("fault %0d, want %0d", m_fault, want.fault));
                end
            end
            m_ready <= ($urandom_range(99) >= rx_idle);
        end
    end

    initial begin
        int base;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed program: "< - . + > , . [ - ] [ + ] ["
        // Covers every instruction, pointer wrap below cell 0 and back above the
        // top, cell wrap both ways, a one-pass loop, a skip over a closed loop,
        // a skip that finds no match, and steps with nothing to run.
        issue(1'b1, bfm_pkg::SYM_CLOSE, 8'h00);      // empty store: halted
        load_sym(bfm_pkg::SYM_LEFT);
        load_sym(bfm_pkg::SYM_DEC);
        load_sym(bfm_pkg::SYM_OUT);
        load_sym(bfm_pkg::SYM_INC);
        load_sym(bfm_pkg::SYM_RIGHT);
        load_sym(bfm_pkg::SYM_IN);
        load_sym(bfm_pkg::SYM_OUT);
        load_sym(bfm_pkg::SYM_OPEN);
        load_sym(bfm_pkg::SYM_DEC);
        load_sym(bfm_pkg::SYM_CLOSE);
        load_sym(bfm_pkg::SYM_OPEN);
        load_sym(bfm_pkg::SYM_INC);
        load_sym(bfm_pkg::SYM_CLOSE);
        load_sym(bfm_pkg::SYM_OPEN);
        while (pc < prog_len)
            issue(1'b1, 3'($urandom),
                  (prog_mem[pc] == bfm_pkg::SYM_IN) ? 8'd1 : rand_byte());
        issue(1'b1, bfm_pkg::SYM_OPEN, 8'hFF);       // past the end after the failed scan

        // Random programs, in three idling regimes. Each switch first lets the
        // block drain completely, so the sender sits idle with nothing in flight.
        base = issued;
        while (issued < base + RANDOM_ITEMS / 3)
            add_chunk();
        wait_all_done();
        tx_idle = 52;
        rx_idle = 34;
        while (issued < base + 2 * RANDOM_ITEMS / 3)
            add_chunk();
        wait_all_done();
        tx_idle = 0;
        rx_idle = 0;
        while (issued < base + RANDOM_ITEMS)
            add_chunk();

        // Both fault endings freeze the program counter for good, so each run
        // takes one of them.
        if ($urandom_range(1)) begin
            // loop stack overflow: one '[' more than the stack holds, cell nonzero
            load_sym(bfm_pkg::SYM_IN);
            repeat (bfm_pkg::LOOP_DEPTH + 1) load_sym(bfm_pkg::SYM_OPEN);
            issue(1'b1, 3'($urandom), 8'($urandom_range(1, 255)));
            repeat (bfm_pkg::LOOP_DEPTH + 2) step_auto();
        end else begin
            // ']' with an empty stack, whatever the cell holds
            load_sym(bfm_pkg::SYM_IN);
            load_sym(bfm_pkg::SYM_CLOSE);
            issue(1'b1, 3'($urandom), rand_byte());
            repeat (3) step_auto();
        end

        // Fill the code store, then push past it.
        while (prog_len < bfm_pkg::CODE_DEPTH) begin
            load_sym(3'($urandom));
            if ($urandom_range(63) == 0)
                step_auto();
        end
        repeat (3) load_sym(3'($urandom));
        step_auto();

        wait_all_done();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule

/* files.f */
src/bfm_pkg.sv
src/bfm_code_store.sv
src/bfm_data_store.sv
src/brainfuck_machine_step_core.sv
tb/sv/tb.sv
